// ===== rtl/mlfd_pkg.sv =====
`timescale 1ns / 1ps

package mlfd_pkg;

	// Header layout: four little-endian 32-bit words
	localparam int unsigned HEADER_BYTES = 16;
	localparam int unsigned HDR_CNT_W    = $clog2(HEADER_BYTES);
	localparam int unsigned HDR_BITS     = HEADER_BYTES * 8;

	localparam logic [HDR_CNT_W-1:0] HDR_CNT_LAST = HDR_CNT_W'(HEADER_BYTES - 1);

	// total length counts the total-length, type and payload-length words plus the payload, all after magic
	localparam logic [31:0] LEN_OVERHEAD = 32'd12;

	localparam logic ERR_MAGIC  = 1'b0;
	localparam logic ERR_LENGTH = 1'b1;

	typedef struct packed {
		logic [7:0]  byte_value;
		logic [63:0] recv_time;
		logic        chunk_last;
	} mlfd_in_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        byte_valid;
		logic [31:0] frame_type;
		logic        frame_last;
		logic [63:0] frame_time;
		logic        error_flag;
		logic        error_kind;
	} mlfd_out_t;

endpackage

// ===== rtl/mlfd_if.sv =====
`timescale 1ns / 1ps

interface mlfd_in_if;
	logic               valid;
	logic               ready;
	mlfd_pkg::mlfd_in_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface mlfd_out_if;
	logic                valid;
	logic                ready;
	mlfd_pkg::mlfd_out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/magic_length_frame_deframer_top.sv =====
`timescale 1ns / 1ps
// Path: an accepted byte beat goes to the input stage, then its result, if any, to the output
//   register (one input stage, one result register), later only if the output side stalls.
// Throughput: one byte beat per cycle when unstalled; set by single-pass header/payload logic.
// Reset: arst_n asynchronous, active low; clears magic_q, parser state, sticky error and
//   both valid flags. Header storage is not reset (every byte is written before it is read).

module magic_length_frame_deframer_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [31:0]       cfg_wdata,
	mlfd_in_if.sink           in_ch,
	mlfd_out_if.source        out_ch
);

	// ---------------------------------------------------------------
	// Configuration: expected magic word
	// ---------------------------------------------------------------
	logic [31:0] magic_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= '0;
		end else if (cfg_wen) begin
			magic_q <= cfg_wdata;
		end
	end

	// ---------------------------------------------------------------
	// Handshake / pipeline control
	//   advance: the result register can take a new value this cycle,
	//   so the s1 beat is consumed and a new input beat may enter.
	// ---------------------------------------------------------------
	logic                valid_s1;
	mlfd_pkg::mlfd_in_t  data_s1;
	logic                out_valid_q;
	mlfd_pkg::mlfd_out_t out_data_q;
	logic                advance;
	logic                step;

	assign advance     = !out_valid_q || out_ch.ready;
	assign step        = valid_s1 && advance;
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// payload stage register, no reset needed
	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			data_s1 <= in_ch.data;
		end
	end

	// ---------------------------------------------------------------
	// Parser state
	// ---------------------------------------------------------------
	logic [mlfd_pkg::HDR_CNT_W-1:0] hdr_cnt_q;
	logic [mlfd_pkg::HDR_BITS-1:0]  header_q;
	logic                           in_pay_q;
	logic [31:0]                    left_q;
	logic [31:0]                    type_q;
	logic                           err_q;

	logic [mlfd_pkg::HDR_CNT_W-1:0] hdr_cnt_d;
	logic                           in_pay_d;
	logic [31:0]                    left_d;
	logic [31:0]                    type_d;
	logic                           err_d;
	logic                           produce;
	mlfd_pkg::mlfd_out_t            res;

	// Header words as seen on the 16th byte; the top byte of the
	// payload-length word is the byte being taken right now.
	logic [31:0] hdr_magic;
	logic [31:0] hdr_total;
	logic [31:0] hdr_type;
	logic [31:0] hdr_plen;
	logic        len_bad;

	assign hdr_magic = header_q[31:0];
	assign hdr_total = header_q[63:32];
	assign hdr_type  = header_q[95:64];
	assign hdr_plen  = {data_s1.byte_value, header_q[119:96]};
	assign len_bad   = (hdr_total < mlfd_pkg::LEN_OVERHEAD) ||
	                   (hdr_plen != (hdr_total - mlfd_pkg::LEN_OVERHEAD));

	always_comb begin
		hdr_cnt_d = hdr_cnt_q;
		in_pay_d  = in_pay_q;
		left_d    = left_q;
		type_d    = type_q;
		err_d     = err_q;
		produce   = 1'b0;
		res       = '0;

		if (!err_q) begin
			if (in_pay_q) begin
				// payload byte: always one result, last one closes the frame
				left_d           = left_q - 32'd1;
				produce          = 1'b1;
				res.payload_byte = data_s1.byte_value;
				res.byte_valid   = 1'b1;
				res.frame_type   = type_q;
				if (left_q == 32'd1) begin
					in_pay_d       = 1'b0;
					res.frame_last = 1'b1;
					res.frame_time = data_s1.recv_time;
				end
			end else begin
				// header byte; counter wraps to zero after the 16th
				hdr_cnt_d = hdr_cnt_q + 1'b1;
				if (hdr_cnt_q == mlfd_pkg::HDR_CNT_LAST) begin
					priority if (hdr_magic != magic_q) begin
						err_d          = 1'b1;
						produce        = 1'b1;
						res.error_flag = 1'b1;
						res.error_kind = mlfd_pkg::ERR_MAGIC;
					end else if (len_bad) begin
						err_d          = 1'b1;
						produce        = 1'b1;
						res.error_flag = 1'b1;
						res.error_kind = mlfd_pkg::ERR_LENGTH;
					end else if (hdr_plen == 32'd0) begin
						// empty frame: one marker result
						type_d         = hdr_type;
						produce        = 1'b1;
						res.frame_type = hdr_type;
						res.frame_last = 1'b1;
						res.frame_time = data_s1.recv_time;
					end else begin
						type_d   = hdr_type;
						left_d   = hdr_plen;
						in_pay_d = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q <= '0;
			in_pay_q  <= 1'b0;
			left_q    <= '0;
			type_q    <= '0;
			err_q     <= 1'b0;
		end else if (step) begin
			hdr_cnt_q <= hdr_cnt_d;
			in_pay_q  <= in_pay_d;
			left_q    <= left_d;
			type_q    <= type_d;
			err_q     <= err_d;
		end
	end

	// header bytes land in their byte lane, little-endian
	always_ff @(posedge clk) begin
		if (step && !in_pay_q && !err_q) begin
			header_q[hdr_cnt_q*8 +: 8] <= data_s1.byte_value;
		end
	end

	// ---------------------------------------------------------------
	// Result register: holds a beat until the sink takes it
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (step && produce) begin
			out_data_q <= res;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;

endmodule

// ===== rtl/mlfd_checker.sv =====
`timescale 1ns / 1ps

module mlfd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input mlfd_pkg::mlfd_out_t out_data
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// error report carries no byte and closes no frame
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error_flag |->
			!out_data.byte_valid && !out_data.frame_last && out_data.frame_type == 32'd0)
		else $error("error report with frame fields set");

	// time only on the closing beat
	a_time_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.frame_last |-> out_data.frame_time == 64'd0)
		else $error("frame_time set without frame_last");

	// a non-byte, non-error beat is the empty-frame marker
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.byte_valid && !out_data.error_flag |-> out_data.frame_last)
		else $error("marker beat without frame_last");

	// stream stops after the error report
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.error_flag |=> !out_valid)
		else $error("result after error report");

endmodule

bind magic_length_frame_deframer_top mlfd_checker u_mlfd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);
